/* hw/rtl/pir_smd_pkg.sv */
// shared types, widths and register codes for the pir slope motion detector
package pir_smd_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int LENGTH_BITS = 16;
	localparam int THRESH_BITS = 12;
	localparam int TICKS_BITS = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	// compare widths cover both operands
	localparam int SWING_CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
	localparam int LEN_CMP_BITS = (LENGTH_BITS > TICKS_BITS) ? LENGTH_BITS : TICKS_BITS;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LENGTH_BITS-1:0] length_t;
	typedef logic [THRESH_BITS-1:0] thresh_t;
	typedef logic [TICKS_BITS-1:0] ticks_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
	typedef logic [SWING_CMP_BITS-1:0] swing_cmp_t;
	typedef logic [LEN_CMP_BITS-1:0] len_cmp_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SWING_THRESHOLD = 2'd0,
		CFG_MIN_SLOPE_TICKS = 2'd1,
		CFG_MAX_SLOPE_TICKS = 2'd2
	} cfg_index_t;

	localparam thresh_t SWING_THRESHOLD_RST = thresh_t'(100);
	localparam ticks_t MIN_SLOPE_TICKS_RST = ticks_t'(100);
	localparam ticks_t MAX_SLOPE_TICKS_RST = ticks_t'(2000);

	localparam length_t LENGTH_ZERO = '0;
	localparam length_t LENGTH_ONE = length_t'(1);
	localparam length_t LENGTH_MAX = '1;

	typedef struct packed {
		thresh_t swing_threshold;
		ticks_t min_slope_ticks;
		ticks_t max_slope_ticks;
	} cfg_t;

endpackage

/* hw/rtl/pir_smd_cfg.sv */
// configuration register file
module pir_smd_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [pir_smd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input pir_smd_pkg::cfg_data_t cfg_data,
	output pir_smd_pkg::cfg_t cfg
);
	import pir_smd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swing_threshold <= SWING_THRESHOLD_RST;
			cfg_q.min_slope_ticks <= MIN_SLOPE_TICKS_RST;
			cfg_q.max_slope_ticks <= MAX_SLOPE_TICKS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SWING_THRESHOLD: cfg_q.swing_threshold <= cfg_data[THRESH_BITS-1:0];
				CFG_MIN_SLOPE_TICKS: cfg_q.min_slope_ticks <= cfg_data[TICKS_BITS-1:0];
				CFG_MAX_SLOPE_TICKS: cfg_q.max_slope_ticks <= cfg_data[TICKS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/pir_smd_tracker.sv */
// slope tracker state and end-of-slope qualification
module pir_smd_tracker (
	input logic clk,
	input logic arst_n,
	input logic step,
	input pir_smd_pkg::sample_t sample,
	input pir_smd_pkg::cfg_t cfg,
	output logic motion_event
);
	import pir_smd_pkg::*;

	sample_t low_q, high_q, low_d, high_d;
	logic rising_q, rising_d;
	length_t len_q, len_d, len_grow;
	sample_t swing;
	logic qualifies;

	// saturating length increment
	assign len_grow = (len_q == LENGTH_MAX) ? len_q : len_q + LENGTH_ONE;

	assign swing = (high_q > low_q) ? high_q - low_q : '0;
	assign qualifies = (swing_cmp_t'(swing) > swing_cmp_t'(cfg.swing_threshold))
		&& (len_cmp_t'(len_q) > len_cmp_t'(cfg.min_slope_ticks))
		&& (len_cmp_t'(len_q) < len_cmp_t'(cfg.max_slope_ticks));

	always_comb begin
		low_d = low_q;
		high_d = high_q;
		rising_d = rising_q;
		len_d = len_q;
		motion_event = 1'b0;
		if (len_q == LENGTH_ZERO) begin
			low_d = sample;
			high_d = '0;
			len_d = LENGTH_ONE;
		end else if (len_q == LENGTH_ONE) begin
			// direction still open, equal sample waits
			if (sample > low_q) begin
				high_d = sample;
				rising_d = 1'b1;
				len_d = len_grow;
			end else if (sample < low_q) begin
				high_d = low_q;
				low_d = sample;
				rising_d = 1'b0;
				len_d = len_grow;
			end
		end else if (!rising_q) begin
			if (sample < low_q) begin
				low_d = sample;
				len_d = len_grow;
			end else begin
				motion_event = qualifies;
				low_d = '0;
				high_d = '0;
				rising_d = 1'b0;
				len_d = LENGTH_ZERO;
			end
		end else begin
			if (sample > high_q) begin
				high_d = sample;
				len_d = len_grow;
			end else begin
				motion_event = qualifies;
				low_d = '0;
				high_d = '0;
				rising_d = 1'b0;
				len_d = LENGTH_ZERO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '0;
			rising_q <= 1'b0;
			len_q <= LENGTH_ZERO;
		end else if (step) begin
			low_q <= low_d;
			high_q <= high_d;
			rising_q <= rising_d;
			len_q <= len_d;
		end
	end

endmodule

/* hw/rtl/pir_slope_motion_detector_core.sv */
// top level of the pir slope motion detector
//
// usage:
//   input channel: in_valid / in_stall with one adc sample per item
//   output channel: out_valid / out_stall with one motion_event per item
//   every accepted sample yields exactly one result, 1 when a qualifying
//   slope ended on that sample and 0 otherwise
//   result path: an accepted sample reaches motion_event through the
//   input register, then the result register
//   throughput: one item per cycle while out_stall is low; the tracker state
//   update is a compare and a saturating increment between the registers
//   stall: while the result register holds an untaken item, the input
//   register still loads once; after that in_stall rises until the result
//   is taken, so no item is dropped or repeated
//   config: plain write port (cfg_write, cfg_index, cfg_data), unknown
//   indexes ignored; users write only while no item is in flight, unchecked
//   reset: arst_n clears both pipeline registers, the tracker (idle) and
//   the thresholds to their defaults (swing 100, min 100, max 2000 ticks)
module pir_slope_motion_detector_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input pir_smd_pkg::sample_t sample,
	output logic out_valid,
	input logic out_stall,
	output logic motion_event,
	input logic cfg_write,
	input logic [pir_smd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input pir_smd_pkg::cfg_data_t cfg_data
);
	import pir_smd_pkg::*;

	cfg_t cfg;

	// input register
	logic valid_s1;
	sample_t sample_s1;

	// result register
	logic out_valid_q;
	logic event_q;
	logic event_d;

	logic advance; // result register free to load
	logic step;    // stage one item is processed this cycle
	logic in_take;

	assign advance = !out_valid_q || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	pir_smd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	pir_smd_tracker u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.sample(sample_s1),
		.cfg(cfg),
		.motion_event(event_d)
	);

	// stage one: holds the accepted sample until the tracker consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
		end
	end

	// result register: loads on step, drains when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= event_d;
		end
	end

	assign out_valid = out_valid_q;
	assign motion_event = event_q;

endmodule

/* tb/pir_smd_event_checker.sv */
`timescale 1ns / 100ps
// event checker: predicts motion_event per sample and compares the result stream
module pir_smd_event_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input pir_smd_pkg::sample_t sample,
	input logic out_valid,
	input logic out_stall,
	input logic motion_event,
	input logic cfg_write,
	input logic [pir_smd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input pir_smd_pkg::cfg_data_t cfg_data,
	output int mismatches,
	output int pending
);
	import pir_smd_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// thresholds as the block should hold them
	thresh_t swing_limit;
	ticks_t len_floor;
	ticks_t len_ceiling;

	// slope tracker copy
	sample_t trough;
	sample_t peak;
	logic climbing;
	length_t run_len;

	logic events_due[$];
	logic due;

	function automatic void extend_run();
		if (run_len != LENGTH_MAX) run_len = run_len + 1'b1;
	endfunction

	function automatic void clear_slope();
		trough = '0;
		peak = '0;
		climbing = 1'b0;
		run_len = LENGTH_ZERO;
	endfunction

	// advance the tracker by one sample, return the expected motion_event
	function automatic logic track_sample(input sample_t s);
		logic fired;
		sample_t swing;
		fired = 1'b0;
		if (run_len == LENGTH_ZERO) begin
			trough = s;
			peak = '0;
			run_len = LENGTH_ONE;
		end else if (run_len == LENGTH_ONE) begin
			if (s > trough) begin
				peak = s;
				climbing = 1'b1;
				extend_run();
			end else if (s < trough) begin
				peak = trough;
				trough = s;
				climbing = 1'b0;
				extend_run();
			end
		end else if ((!climbing && s < trough) || (climbing && s > peak)) begin
			if (climbing) peak = s;
			else trough = s;
			extend_run();
		end else begin
			swing = (peak > trough) ? sample_t'(peak - trough) : sample_t'(0);
			fired = (swing > swing_limit) && (run_len > len_floor) && (run_len < len_ceiling);
			clear_slope();
		end
		return fired;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swing_limit = SWING_THRESHOLD_RST;
			len_floor = MIN_SLOPE_TICKS_RST;
			len_ceiling = MAX_SLOPE_TICKS_RST;
			clear_slope();
			events_due.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_SWING_THRESHOLD: swing_limit = thresh_t'(cfg_data);
					CFG_MIN_SLOPE_TICKS: len_floor = ticks_t'(cfg_data);
					CFG_MAX_SLOPE_TICKS: len_ceiling = ticks_t'(cfg_data);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (events_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: motion_event %0b with no item due", $realtime, motion_event);
				end else begin
					due = events_due.pop_front();
					if (motion_event !== due) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: motion_event expected %0b, got %0b",
								$realtime, due, motion_event);
					end
				end
			end
			if (in_valid && !in_stall) events_due.push_back(track_sample(sample));
			pending = events_due.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench top: drives samples and thresholds into the pir slope motion detector
module tb;
	import pir_smd_pkg::*;

	// no-acceptance cycles before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	// result path is two registers deep, give it a little slack
	localparam int DRAIN_CYCLES = 8;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 125;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	// index the block must ignore
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	sample_t sample = '0;
	logic out_stall = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	cfg_data_t cfg_data = '0;

	logic in_stall;
	logic out_valid;
	logic motion_event;
	int mismatches;
	int pending;

	int gap_pct = 0;
	int stall_pct = 0;
	int samples_sent = 0;
	int quiet_cycles = 0;
	int phase;

	// default thresholds: every slope here is far too short to qualify
	sample_t directed_default[8] = '{12'd0, 12'd0, 12'd4095, 12'd4095,
		12'd4095, 12'd4095, 12'd0, 12'd1};
	// wide-open thresholds: rising by one, falling by one, held start then a turn
	sample_t directed_open[12] = '{12'd0, 12'd1, 12'd1, 12'd4095, 12'd4094, 12'd4095,
		12'd5, 12'd5, 12'd5, 12'd6, 12'd7, 12'd2};
	// max ticks of two: a two-sample slope sits on the upper bound
	sample_t directed_tight[3] = '{12'd10, 12'd20, 12'd20};

	always #2 clk = ~clk;

	pir_slope_motion_detector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.motion_event(motion_event),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pir_smd_event_checker u_event_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.motion_event(motion_event),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog: any accepted item or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				gap_pct = 71;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 71;
			end
			IDLE_BOTH: begin
				gap_pct = 37;
				stall_pct = 37;
			end
			default: begin
				gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// one sample item, entered and left at a falling edge; random gaps ahead of it
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	// sender holds off until every result is back, then lets the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// writes all three thresholds plus a junk write to the unused index;
	// the swing write carries random bits above the 12-bit register
	task automatic program_thresholds(input thresh_t swing, input ticks_t lo, input ticks_t hi);
		cfg_data_t padded;
		padded = cfg_data_t'($urandom);
		padded[THRESH_BITS-1:0] = swing;
		cfg_write <= 1'b1;
		cfg_index <= CFG_SWING_THRESHOLD;
		cfg_data <= padded;
		@(negedge clk);
		cfg_index <= CFG_MIN_SLOPE_TICKS;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= CFG_MAX_SLOPE_TICKS;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= cfg_data_t'($urandom);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// one well-formed slope: start, optional held repeats while the direction
	// is open, strictly monotonic steps, then a closing sample that is equal,
	// a turn back, or anything at all
	task automatic send_slope(input bit up, input int steps, input int max_step, input int holds);
		int cur;
		int stride;
		int k;
		cur = up ? $urandom_range(SAMPLE_MAX - steps, 0) : $urandom_range(SAMPLE_MAX, steps);
		send_sample(sample_t'(cur));
		repeat (holds) send_sample(sample_t'(cur));
		k = 0;
		stride = 1;
		while (k < steps && stride != 0) begin
			stride = $urandom_range(max_step, 1);
			if (up && stride > SAMPLE_MAX - cur) stride = SAMPLE_MAX - cur;
			if (!up && stride > cur) stride = cur;
			if (stride != 0) begin
				cur = up ? cur + stride : cur - stride;
				send_sample(sample_t'(cur));
			end
			k++;
		end
		case ($urandom_range(3))
			0: send_sample(sample_t'(cur));
			1: begin
				stride = $urandom_range(max_step, 1);
				if (up) cur = (cur >= stride) ? cur - stride : 0;
				else cur = (cur + stride <= SAMPLE_MAX) ? cur + stride : SAMPLE_MAX;
				send_sample(sample_t'(cur));
			end
			default: send_sample(sample_t'($urandom));
		endcase
	endtask

	// mostly slopes with random content, some long enough for the default
	// minimum, plus bursts of noise; a full drain halfway through
	task automatic run_phase(input int quota);
		int first;
		int pick;
		bit drained;
		first = samples_sent;
		drained = 1'b0;
		while (samples_sent - first < quota) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				repeat ($urandom_range(6, 1)) send_sample(sample_t'($urandom));
			end else if (pick < 27) begin
				send_slope(1'($urandom_range(1)), $urandom_range(160, 90),
					$urandom_range(20, 1), 0);
			end else begin
				send_slope(1'($urandom_range(1)), $urandom_range(24), $urandom_range(200, 1),
					($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0);
			end
			if (!drained && samples_sent - first >= quota / 2) begin
				drain_results();
				drained = 1'b1;
			end
		end
	endtask

	initial begin
		set_idling(IDLE_NONE);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset thresholds, then extremes
		foreach (directed_default[i]) send_sample(directed_default[i]);
		drain_results();
		program_thresholds('0, '0, '1);
		foreach (directed_open[i]) send_sample(directed_open[i]);
		drain_results();
		program_thresholds('0, '0, ticks_t'(2));
		foreach (directed_tight[i]) send_sample(directed_tight[i]);

		// random: each phase gets its own thresholds and idling pattern
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: program_thresholds(SWING_THRESHOLD_RST, MIN_SLOPE_TICKS_RST,
					MAX_SLOPE_TICKS_RST);
				// everything with any swing qualifies
				1: program_thresholds('0, '0, '1);
				// nothing can qualify
				2: program_thresholds('1, '1, '0);
				default: begin
					int lo;
					lo = $urandom_range(12);
					program_thresholds(thresh_t'($urandom_range(250)), ticks_t'(lo),
						ticks_t'(lo + $urandom_range(60, 2)));
				end
			endcase
			set_idling(idle_mode_t'(phase % 4));
			run_phase(PHASE_SAMPLES);
		end

		drain_results();
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
